// ----- hdl/assert_macros.svh -----
// assertion macros used by the controller of the bar graph renderer
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under async active-low reset
`define SBGR_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sbgr assertion failed");

// next-cycle implication under async active-low reset
`define SBGR_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sbgr assertion failed");

`endif

// ----- hdl/sbgr_pkg.sv -----
// package of the spectrum bar graph renderer: widths, codes, item and control types
// no dependencies
`default_nettype none

package sbgr_pkg;

	// field and state widths
	localparam int SUM_W       = 22;
	localparam int FILL_W      = 7;
	localparam int STEP_W      = 7;
	localparam int BIN_W       = 16;
	localparam int COLOR_W     = 32;
	localparam int COL_FIELD_W = 5;
	localparam int ROW_FIELD_W = 3;
	localparam int REM_W       = 6;

	// divider runs one quotient bit per cycle over the window sum
	localparam int DIV_BITS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_BITS);

	// step limits and reset value
	localparam logic [STEP_W-1:0] STEP_MIN   = 7'd1;
	localparam logic [STEP_W-1:0] STEP_MAX   = 7'd64;
	localparam logic [STEP_W-1:0] STEP_RESET = 7'd4;

	// level quantum of 4: level > row exactly when average > 4*row
	localparam int LEVEL_SHIFT = 2;

	// row color table
	localparam int TABLE_DEPTH = 8;
	localparam logic [COLOR_W-1:0] COLOR_BLANK = 32'h0000_0000;

	// default geometry
	localparam int WIDTH_DEF  = 32;
	localparam int HEIGHT_DEF = 8;

	// item mode codes
	localparam logic MODE_BIN   = 1'b0;
	localparam logic MODE_COLOR = 1'b1;

	typedef struct packed {
		logic                   mode;
		logic                   frame_start;
		logic [BIN_W-1:0]       bin_value;
		logic [ROW_FIELD_W-1:0] row_index;
		logic [COLOR_W-1:0]     color_word;
	} in_item_t;

	typedef struct packed {
		logic [COL_FIELD_W-1:0] column;
		logic [ROW_FIELD_W-1:0] row;
		logic [COLOR_W-1:0]     pixel_color;
		logic                   last;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic take_item;
		logic div_step;
		logic row_next;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic win_close;
		logic row_last;
	} stat_t;

endpackage

`default_nettype wire

// ----- hdl/sbgr_ctrl.sv -----
// controller of the bar graph renderer: accept, divide and pixel emit sequencing
// depends on sbgr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sbgr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire sbgr_pkg::stat_t stat,
	output sbgr_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [sbgr_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (stat.win_close) begin
						state_d = ST_DIV;
						cnt_d = sbgr_pkg::DIV_CNT_W'(sbgr_pkg::DIV_BITS - 1);
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.row_next = 1'b1;
					if (stat.row_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	// checks
	`SBGR_ASSERT_IMP(a_ready_excl, clk, arst_n, in_ready, !out_valid)
	`SBGR_ASSERT_NXT(a_close_busy, clk, arst_n, in_valid && in_ready && stat.win_close, !in_ready && !out_valid)
	`SBGR_ASSERT_NXT(a_div_to_emit, clk, arst_n, cmd.div_step && cnt_q == '0, out_valid)
	`SBGR_ASSERT_NXT(a_last_to_idle, clk, arst_n, out_valid && out_ready && stat.row_last, in_ready)

endmodule

`default_nettype wire

// ----- hdl/sbgr_dpath.sv -----
// datapath of the bar graph renderer: window accumulator, step register,
// serial divider, row color table and pixel output; depends on sbgr_pkg
`default_nettype none

module sbgr_dpath #(
	parameter int WIDTH  = sbgr_pkg::WIDTH_DEF,
	parameter int HEIGHT = sbgr_pkg::HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sbgr_pkg::STEP_W-1:0] cfg_wdata,
	input  wire sbgr_pkg::in_item_t          in_data,
	output sbgr_pkg::out_item_t              out_data,
	input  wire sbgr_pkg::cmd_t              cmd,
	output sbgr_pkg::stat_t                  stat
);

	localparam int CIW  = $clog2(WIDTH + 1);
	localparam int ROWS = (HEIGHT > sbgr_pkg::TABLE_DEPTH) ? sbgr_pkg::TABLE_DEPTH : HEIGHT;

	logic [sbgr_pkg::STEP_W-1:0]  step_q;
	logic [sbgr_pkg::SUM_W-1:0]   sum_q;
	logic [sbgr_pkg::FILL_W-1:0]  fill_q;
	logic [CIW-1:0]               col_q;
	logic [sbgr_pkg::COLOR_W-1:0] color_q [sbgr_pkg::TABLE_DEPTH];
	logic [sbgr_pkg::ROW_FIELD_W-1:0] row_q;

	logic [sbgr_pkg::SUM_W-1:0]   quo_q;
	logic [sbgr_pkg::REM_W-1:0]   rem_q;
	logic [sbgr_pkg::STEP_W-1:0]  dvs_q;
	logic [CIW-1:0]               ocol_q;

	logic [sbgr_pkg::STEP_W-1:0]  step_eff, len;
	logic [sbgr_pkg::SUM_W-1:0]   sum_eff, sum_new;
	logic [sbgr_pkg::FILL_W-1:0]  fill_eff, fill_new;
	logic [CIW-1:0]               col_eff;
	logic                         active, is_bin;
	logic [sbgr_pkg::REM_W:0]     trial;
	logic                         qbit;

	// window bookkeeping for the offered item, and row status
	always_comb begin
		is_bin = (in_data.mode == sbgr_pkg::MODE_BIN);
		col_eff = in_data.frame_start ? '0 : col_q;
		sum_eff = in_data.frame_start ? '0 : sum_q;
		fill_eff = in_data.frame_start ? '0 : fill_q;
		active = (col_eff < CIW'(WIDTH));
		step_eff = step_q;
		if (step_q == '0) begin
			step_eff = sbgr_pkg::STEP_MIN;
		end else if (step_q > sbgr_pkg::STEP_MAX) begin
			step_eff = sbgr_pkg::STEP_MAX;
		end
		// first window of a frame is the upper half of a step
		len = (col_eff == '0) ? (step_eff - (step_eff >> 1)) : step_eff;
		sum_new = sum_eff + sbgr_pkg::SUM_W'(in_data.bin_value);
		fill_new = fill_eff + 1'b1;
		stat.win_close = is_bin && active && (fill_new >= len);
		stat.row_last = (row_q == sbgr_pkg::ROW_FIELD_W'(ROWS - 1));
	end

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sbgr_pkg::STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	// window accumulator, column counter, color table, row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			fill_q <= '0;
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < sbgr_pkg::TABLE_DEPTH; i++) begin
				color_q[i] <= sbgr_pkg::COLOR_BLANK;
			end
		end else begin
			if (cmd.take_item) begin
				row_q <= '0;
				if (!is_bin) begin
					color_q[in_data.row_index] <= in_data.color_word;
				end else if (active) begin
					if (stat.win_close) begin
						sum_q <= '0;
						fill_q <= '0;
						col_q <= col_eff + 1'b1;
					end else begin
						sum_q <= sum_new;
						fill_q <= fill_new;
						col_q <= col_eff;
					end
				end
			end
			if (cmd.row_next) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// restoring divider step
	always_comb begin
		trial = {rem_q, quo_q[sbgr_pkg::SUM_W-1]};
		qbit = (trial >= dvs_q);
	end

	// divider operands and quotient
	always_ff @(posedge clk) begin
		if (cmd.take_item && stat.win_close) begin
			quo_q <= sum_new;
			rem_q <= '0;
			dvs_q <= len;
			ocol_q <= col_eff;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[sbgr_pkg::SUM_W-2:0], qbit};
			rem_q <= qbit ? sbgr_pkg::REM_W'(trial - dvs_q) : trial[sbgr_pkg::REM_W-1:0];
		end
	end

	// pixel output
	always_comb begin
		out_data.column = sbgr_pkg::COL_FIELD_W'(ocol_q);
		out_data.row = row_q;
		out_data.last = stat.row_last;
		out_data.pixel_color = sbgr_pkg::COLOR_BLANK;
		if (quo_q > (sbgr_pkg::SUM_W'(row_q) << sbgr_pkg::LEVEL_SHIFT)) begin
			out_data.pixel_color = color_q[row_q];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/spectrum_bar_graph_renderer.sv -----
// top level of the spectrum bar graph renderer: controller plus datapath
// depends on sbgr_pkg, sbgr_ctrl and sbgr_dpath
//
// channel   handshake            payload
// in        in_valid/in_ready    in_data  (sbgr_pkg::in_item_t)
// out       out_valid/out_ready  out_data (sbgr_pkg::out_item_t)
// cfg       cfg_we               cfg_wdata (avg_step, 7 bits)
//
// color writes and bins that do not close a window leave in_ready high
// a closing bin starts the divider (one quotient bit per cycle over the sum)
// then min(HEIGHT,8) pixel items, one per cycle while out_ready is high
// in_ready stays low from a closing bin until its last pixel is taken
// reset clears all but the divider registers at once; no clearing pass
`default_nettype none

module spectrum_bar_graph_renderer #(
	parameter int WIDTH  = sbgr_pkg::WIDTH_DEF,
	parameter int HEIGHT = sbgr_pkg::HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sbgr_pkg::STEP_W-1:0] cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire sbgr_pkg::in_item_t          in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output sbgr_pkg::out_item_t              out_data
);

	sbgr_pkg::cmd_t  cmd;
	sbgr_pkg::stat_t stat;

	// sequencing
	sbgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// accumulate, divide, render
	sbgr_dpath #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

// ----- bench/spectrum_bar_graph_renderer_test.sv -----
// self-checking bench for spectrum_bar_graph_renderer: directed table, then random phases
// depends on sbgr_pkg and the renderer rtl; pixel items are checked against an in-bench predictor
`default_nettype none

module spectrum_bar_graph_renderer_test;

	localparam int BAR_ROWS     = (sbgr_pkg::HEIGHT_DEF < sbgr_pkg::TABLE_DEPTH) ?
		sbgr_pkg::HEIGHT_DEF : sbgr_pkg::TABLE_DEPTH;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 200000;

	// how a directed row is checked
	typedef enum {CHK_MODEL, CHK_QUIET, CHK_BAR} chk_t;

	typedef struct {
		sbgr_pkg::in_item_t it;
		chk_t               chk;
		int                 t_col;
		int                 t_lev;
	} probe_t;

	typedef struct {
		logic [sbgr_pkg::STEP_W-1:0] step;
		int                          n_items;
		int                          fs_pct;
		bit                          lead_fs;
		int                          gap;
		int                          stall;
	} phase_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [sbgr_pkg::STEP_W-1:0] cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	sbgr_pkg::in_item_t          in_data;
	logic                        out_valid;
	logic                        out_ready;
	sbgr_pkg::out_item_t         out_data;

	// predictor state
	logic [sbgr_pkg::STEP_W-1:0]  step_reg;
	logic [sbgr_pkg::SUM_W-1:0]   acc_sum;
	logic [sbgr_pkg::FILL_W-1:0]  acc_fill;
	int                           col_idx;
	logic [sbgr_pkg::COLOR_W-1:0] bar_color [sbgr_pkg::TABLE_DEPTH];

	sbgr_pkg::out_item_t pending_pixels [$];
	sbgr_pkg::out_item_t want_px;
	probe_t              dir_tab [$];
	phase_t              plan [$];

	int gap_pct;
	int stall_pct;
	int mismatches;
	int items_sent;
	int pixels_seen;
	int columns_drawn;
	int step_writes;
	int cycle_cnt;

	spectrum_bar_graph_renderer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock, period 4
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// compare each accepted pixel item with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel item: column %0d row %0d color %h",
					out_data.column, out_data.row, out_data.pixel_color);
				mismatches++;
			end else begin
				want_px = pending_pixels.pop_front();
				pixels_seen++;
				if (out_data.column !== want_px.column) begin
					$error("column: expected %0d, got %0d", want_px.column, out_data.column);
					mismatches++;
				end
				if (out_data.row !== want_px.row) begin
					$error("row: expected %0d, got %0d", want_px.row, out_data.row);
					mismatches++;
				end
				if (out_data.pixel_color !== want_px.pixel_color) begin
					$error("pixel_color: expected %h, got %h",
						want_px.pixel_color, out_data.pixel_color);
					mismatches++;
				end
				if (out_data.last !== want_px.last) begin
					$error("last: expected %0d, got %0d", want_px.last, out_data.last);
					mismatches++;
				end
			end
		end
	end

	// predictor: advance window state, return the bar level of a finished column or -1
	function automatic int column_level(input sbgr_pkg::in_item_t it, output int col);
		int eff;
		int len;
		int avg;
		col = 0;
		if (it.mode == sbgr_pkg::MODE_COLOR) begin
			bar_color[it.row_index] = it.color_word;
			return -1;
		end
		if (it.frame_start) begin
			acc_sum = '0;
			acc_fill = '0;
			col_idx = 0;
		end
		if (col_idx >= sbgr_pkg::WIDTH_DEF)
			return -1;
		// out-of-range step is clamped to 1..64
		eff = (step_reg == '0) ? 1 :
			((step_reg > sbgr_pkg::STEP_MAX) ? int'(sbgr_pkg::STEP_MAX) : int'(step_reg));
		// first window of a frame is shortened
		len = (col_idx == 0) ? eff - eff / 2 : eff;
		acc_sum = acc_sum + sbgr_pkg::SUM_W'(it.bin_value);
		acc_fill = acc_fill + 1'b1;
		if (int'(acc_fill) < len)
			return -1;
		avg = int'(acc_sum) / len;
		col = col_idx;
		acc_sum = '0;
		acc_fill = '0;
		col_idx++;
		return (avg + 3) / 4;
	endfunction

	// queue the pixel run of one column
	function automatic void push_bar(input int col, input int lev);
		sbgr_pkg::out_item_t px;
		for (int y = 0; y < BAR_ROWS; y++) begin
			px.column      = col[sbgr_pkg::COL_FIELD_W-1:0];
			px.row         = y[sbgr_pkg::ROW_FIELD_W-1:0];
			px.pixel_color = (lev > y) ? bar_color[y] : sbgr_pkg::COLOR_BLANK;
			px.last        = (y == BAR_ROWS - 1);
			pending_pixels.push_back(px);
		end
		columns_drawn++;
	endfunction

	function automatic void add_row(input logic md, input logic fs,
			input logic [sbgr_pkg::BIN_W-1:0] bin,
			input logic [sbgr_pkg::ROW_FIELD_W-1:0] ri,
			input logic [sbgr_pkg::COLOR_W-1:0] cw,
			input chk_t chk, input int col, input int lev);
		probe_t r;
		r.it.mode        = md;
		r.it.frame_start = fs;
		r.it.bin_value   = bin;
		r.it.row_index   = ri;
		r.it.color_word  = cw;
		r.chk            = chk;
		r.t_col          = col;
		r.t_lev          = lev;
		dir_tab.push_back(r);
	endfunction

	function automatic void add_phase(input logic [sbgr_pkg::STEP_W-1:0] step, input int n,
			input int fs, input bit lead, input int gap, input int stall);
		phase_t ph;
		ph.step    = step;
		ph.n_items = n;
		ph.fs_pct  = fs;
		ph.lead_fs = lead;
		ph.gap     = gap;
		ph.stall   = stall;
		plan.push_back(ph);
	endfunction

	// random item: mostly bins with small magnitudes so bar levels vary
	function automatic sbgr_pkg::in_item_t rand_item(input int fs_pct);
		sbgr_pkg::in_item_t it;
		int sel;
		sel = $urandom_range(9);
		it.mode        = ($urandom_range(99) < 8) ? sbgr_pkg::MODE_COLOR : sbgr_pkg::MODE_BIN;
		it.frame_start = ($urandom_range(99) < fs_pct);
		if (it.mode == sbgr_pkg::MODE_COLOR)
			it.frame_start = 1'($urandom_range(1));
		case (sel)
			0, 1, 2, 3: it.bin_value = sbgr_pkg::BIN_W'($urandom_range(36));
			4, 5:       it.bin_value = sbgr_pkg::BIN_W'($urandom_range(255));
			6:          it.bin_value = '0;
			7:          it.bin_value = '1;
			default:    it.bin_value = sbgr_pkg::BIN_W'($urandom);
		endcase
		it.row_index  = sbgr_pkg::ROW_FIELD_W'($urandom);
		it.color_word = $urandom;
		return it;
	endfunction

	// offer one item with random sender gaps; returns at the falling edge after acceptance
	task automatic push_item(input sbgr_pkg::in_item_t it);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
		@(negedge clk);
	endtask

	// write avg_step once the block has gone quiet
	task automatic write_step(input logic [sbgr_pkg::STEP_W-1:0] v);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we   <= 1'b0;
		step_reg = v;
		step_writes++;
	endtask

	initial begin
		sbgr_pkg::in_item_t it;
		int col;
		int lev;

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		gap_pct    = 0;
		stall_pct  = 0;
		mismatches = 0;
		items_sent = 0;
		pixels_seen = 0;
		columns_drawn = 0;
		step_writes = 0;
		cycle_cnt  = 0;

		// predictor reset values
		step_reg = sbgr_pkg::STEP_RESET;
		acc_sum  = '0;
		acc_fill = '0;
		col_idx  = 0;
		for (int k = 0; k < sbgr_pkg::TABLE_DEPTH; k++)
			bar_color[k] = sbgr_pkg::COLOR_BLANK;

		// directed rows, avg_step at its reset value of 4 (first window 2 bins)
		// no frame start yet, blank colors after reset
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'hFFFF, 3'd0, 32'h0,         CHK_BAR,   0, 16384);
		// color table loads; frame start and bin are ignored on a color write
		add_row(sbgr_pkg::MODE_COLOR, 1'b1, 16'hFFFF, 3'd0, 32'hFFFF_FFFF, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_COLOR, 1'b0, 16'h0,    3'd1, 32'h0000_0001, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_COLOR, 1'b0, 16'h0,    3'd2, 32'hA5A5_A5A5, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_COLOR, 1'b0, 16'h0,    3'd3, 32'h0000_0000, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_COLOR, 1'b0, 16'h0,    3'd4, 32'h1234_5678, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_COLOR, 1'b0, 16'h0,    3'd5, 32'h8000_0000, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_COLOR, 1'b0, 16'h0,    3'd6, 32'h0000_FFFF, CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_COLOR, 1'b0, 16'h0,    3'd7, 32'hFFFF_0000, CHK_QUIET, 0, 0);
		// new frame, empty bar in column 0
		add_row(sbgr_pkg::MODE_BIN,   1'b1, 16'h0,    3'd7, 32'h0,         CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'h0,    3'd0, 32'h0,         CHK_BAR,   0, 0);
		// full-height bar from the largest bins
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'hFFFF, 3'd0, 32'h0,         CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'hFFFF, 3'd0, 32'h0,         CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'hFFFF, 3'd0, 32'h0,         CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'hFFFF, 3'd0, 32'h0,         CHK_BAR,   1, 16384);
		// average floors to zero
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd1,    3'd0, 32'h0,         CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd0,    3'd0, 32'h0,         CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd0,    3'd0, 32'h0,         CHK_QUIET, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd0,    3'd0, 32'h0,         CHK_BAR,   2, 0);
		// level rounds up
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd4,    3'd0, 32'h0,         CHK_MODEL, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd4,    3'd0, 32'h0,         CHK_MODEL, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd4,    3'd0, 32'h0,         CHK_MODEL, 0, 0);
		add_row(sbgr_pkg::MODE_BIN,   1'b0, 16'd8,    3'd0, 32'h0,         CHK_MODEL, 0, 0);
		// frame start right after a window has closed
		add_row(sbgr_pkg::MODE_BIN,   1'b1, 16'd7,    3'd0, 32'h0,         CHK_MODEL, 0, 0);

		// random phases: sender dense / receiver busy, then swapped, then free running
		add_phase(7'd1,   36, 0,  1'b1, 7,  64);
		add_phase(7'd0,   10, 15, 1'b0, 7,  64);
		add_phase(7'd65,  12, 0,  1'b1, 7,  64);
		add_phase(7'd127, 20, 0,  1'b0, 64, 7);
		add_phase(7'd2,   12, 10, 1'b1, 64, 7);
		add_phase(7'd3,   8,  10, 1'b0, 0,  0);
		add_phase(7'd5,   7,  5,  1'b1, 0,  0);

		// hold reset, then release it at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < dir_tab.size(); i++) begin
			push_item(dir_tab[i].it);
			lev = column_level(dir_tab[i].it, col);
			case (dir_tab[i].chk)
				CHK_MODEL: begin
					if (lev >= 0)
						push_bar(col, lev);
				end
				CHK_BAR: push_bar(dir_tab[i].t_col, dir_tab[i].t_lev);
				CHK_QUIET: ;
			endcase
		end

		// random phases, step rewritten while idle
		for (int p = 0; p < plan.size(); p++) begin
			write_step(plan[p].step);
			gap_pct   = plan[p].gap;
			stall_pct = plan[p].stall;
			for (int i = 0; i < plan[p].n_items; i++) begin
				// hold off once until the output side has drained
				if (p == 0 && i == 18) begin
					in_valid <= 1'b0;
					do @(negedge clk); while (pending_pixels.size() != 0);
				end
				it = rand_item(plan[p].fs_pct);
				if (i == 0 && plan[p].lead_fs) begin
					it.mode        = sbgr_pkg::MODE_BIN;
					it.frame_start = 1'b1;
				end
				push_item(it);
				lev = column_level(it, col);
				if (lev >= 0)
					push_bar(col, lev);
			end
		end

		// drain
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_pixels.size() != 0);
		repeat (DRAIN_CYCLES + 8) @(negedge clk);

		$display("tb: %0d items in, %0d columns and %0d pixel items compared",
			items_sent, columns_drawn, pixels_seen);
		$display("tb: %0d avg_step settings incl. 0, 1 and clamped values", step_writes);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
